>>> hw/rtl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
package mlr_pkg;

    // Default coordinate width in bits.
    localparam int COORD_BITS_DEF = 10;

    // Request kinds carried on the input tuser.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Walker state. A vertical line walks exactly like a steep one whose
    // minor span is zero, so it shares the steep state.
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_GENTLE = 3'b010,
        MODE_STEEP  = 3'b100
    } walk_mode_t;

    // Control that travels with one computed result.
    typedef struct packed {
        logic valid;
        logic last;
    } res_ctrl_t;

endpackage

>>> hw/rtl/mlr_in_stage.sv
// Input register for request transactions.
module mlr_in_stage import mlr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_req,
    input  logic [4*COORD_BITS-1:0]   in_coords,
    input  logic                      advance,
    output logic                      item_valid,
    output logic                      item_req,
    output logic [4*COORD_BITS-1:0]   item_coords
);

    logic                    valid_reg, valid_next;
    logic                    req_reg;
    logic [4*COORD_BITS-1:0] coords_reg;

    // The register can take a new item whenever it is empty or its item is
    // being consumed in this cycle.
    assign in_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            req_reg    <= in_req;
            coords_reg <= in_coords;
        end
    end

    assign item_valid  = valid_reg;
    assign item_req    = req_reg;
    assign item_coords = coords_reg;

endmodule

>>> hw/rtl/mlr_walker.sv
// Line walker: holds the line state and computes at most one pixel per request.
module mlr_walker import mlr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  logic                    item_req,
    input  logic [4*COORD_BITS-1:0] item_coords,
    output res_ctrl_t               res_ctrl,
    output logic [COORD_BITS-1:0]   res_x,
    output logic [COORD_BITS:0]     res_y
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 3;
    localparam logic [CB-1:0] ONE = CB'(1);

    walk_mode_t        mode_reg, mode_next;
    logic [CB-1:0]     base_x_reg, base_x_next;
    logic [CB-1:0]     base_y_reg, base_y_next;
    logic              xneg_reg, xneg_next;
    logic              yneg_reg, yneg_next;
    logic [CB-1:0]     span_x_reg, span_x_next;
    logic [CB-1:0]     span_y_reg, span_y_next;
    logic [CB-1:0]     major_reg, major_next;
    logic [CB-1:0]     minor_reg, minor_next;
    logic [DW-1:0]     err_reg, err_next;

    logic [CB-1:0]     x0, y0, x1, y1;
    logic [CB:0]       dx, dy, dx_abs, dy_abs;
    logic [CB-1:0]     st_span_x, st_span_y, st_major, st_minor;
    logic              st_xneg, st_yneg, st_gentle, st_degen, st_last;
    logic [DW-1:0]     st_err;

    logic              gentle;
    logic [CB-1:0]     mj, mn, k1, i1, x_ofs, y_ofs;
    logic              inc, fin;
    logic [DW-1:0]     err1;
    logic [CB-1:0]     step_x;
    logic [CB:0]       step_y;

    assign x0 = item_coords[CB-1:0];
    assign y0 = item_coords[2*CB-1:CB];
    assign x1 = item_coords[3*CB-1:2*CB];
    assign y1 = item_coords[4*CB-1:3*CB];

    always_comb begin
        // Start path: spans, signs and the classification of the new line.
        dx        = {1'b0, x1} - {1'b0, x0};
        dy        = {1'b0, y1} - {1'b0, y0};
        dx_abs    = dx[CB] ? (~dx + 1'b1) : dx;
        dy_abs    = dy[CB] ? (~dy + 1'b1) : dy;
        st_span_x = dx_abs[CB-1:0];
        st_span_y = dy_abs[CB-1:0];
        st_xneg   = dx[CB] || (dx == '0);
        st_yneg   = dy[CB] || (dy == '0);
        st_degen  = (st_span_x == '0) && (st_span_y == '0);
        st_gentle = (st_span_x != '0) && (st_span_y <= st_span_x);
        st_major  = st_gentle ? st_span_x : st_span_y;
        st_minor  = st_gentle ? st_span_y : st_span_x;
        st_last   = (st_major == ONE);
        // The first pixel is settled in closed form; the term left for the
        // second pixel is 2*minor - major in every case.
        st_err    = {2'b00, st_minor, 1'b0} - {3'b000, st_major};

        // Step path: one midpoint decision on the stored state.
        gentle = (mode_reg == MODE_GENTLE);
        mj     = gentle ? span_x_reg : span_y_reg;
        mn     = gentle ? span_y_reg : span_x_reg;
        inc    = !err_reg[DW-1] && (err_reg != '0);
        k1     = minor_reg + CB'(inc);
        err1   = err_reg - (inc ? {2'b00, mj, 1'b0} : DW'(0)) + {2'b00, mn, 1'b0};
        i1     = major_reg + ONE;
        fin    = (i1 >= mj);
        x_ofs  = gentle ? major_reg : k1;
        y_ofs  = gentle ? k1 : major_reg;
        step_x = xneg_reg ? (base_x_reg - x_ofs) : (base_x_reg + x_ofs);
        step_y = yneg_reg ? ({1'b0, base_y_reg} - {1'b0, y_ofs})
                          : ({1'b0, base_y_reg} + {1'b0, y_ofs});
        // Steep and vertical lines drawn downward sit one row lower.
        step_y = step_y - (CB + 1)'(!gentle && yneg_reg);

        mode_next   = mode_reg;
        base_x_next = base_x_reg;
        base_y_next = base_y_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        span_x_next = span_x_reg;
        span_y_next = span_y_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        err_next    = err_reg;
        res_ctrl    = '0;
        res_x       = step_x;
        res_y       = step_y;

        if (advance) begin
            if (item_req == REQ_START) begin
                base_x_next = x0;
                base_y_next = y0;
                xneg_next   = st_xneg;
                yneg_next   = st_yneg;
                span_x_next = st_span_x;
                span_y_next = st_span_y;
                major_next  = ONE;
                minor_next  = (st_gentle && st_yneg) ? ONE : '0;
                err_next    = st_err;
                if (st_degen || st_last) begin
                    mode_next = MODE_IDLE;
                end else if (st_gentle) begin
                    mode_next = MODE_GENTLE;
                end else begin
                    mode_next = MODE_STEEP;
                end
                res_ctrl.valid = !st_degen;
                res_ctrl.last  = st_last;
                res_x          = x0;
                res_y          = {1'b0, y0} - (CB + 1)'(st_yneg);
            end else if (mode_reg != MODE_IDLE) begin
                major_next     = i1;
                minor_next     = k1;
                err_next       = err1;
                mode_next      = fin ? MODE_IDLE : mode_reg;
                res_ctrl.valid = 1'b1;
                res_ctrl.last  = fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_x_reg <= base_x_next;
        base_y_reg <= base_y_next;
        xneg_reg   <= xneg_next;
        yneg_reg   <= yneg_next;
        span_x_reg <= span_x_next;
        span_y_reg <= span_y_next;
        major_reg  <= major_next;
        minor_reg  <= minor_next;
        err_reg    <= err_next;
    end

endmodule

>>> hw/rtl/mlr_out_stage.sv
// Result register that drives the pixel channel.
module mlr_out_stage import mlr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  res_ctrl_t             res_ctrl,
    input  logic [COORD_BITS-1:0] res_x,
    input  logic [COORD_BITS:0]   res_y,
    output logic                  load_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS:0]   out_y,
    output logic                  out_last
);

    logic                  valid_reg, valid_next;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS:0]   y_reg;
    logic                  last_reg;

    // A new result may be written when the register is empty or being read.
    assign load_ok = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = res_ctrl.valid;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_ctrl.valid) begin
            x_reg    <= res_x;
            y_reg    <= res_y;
            last_reg <= res_ctrl.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_last  = last_reg;

endmodule

>>> hw/rtl/midpoint_line_rasterizer_top.sv
// Top level of the midpoint line rasterizer.
//
// The slave channel takes request transactions. tuser says what a request is:
// a start request carries both endpoints in tdata and yields the first pixel
// of a new line; a step request ignores tdata and yields the next pixel of
// the active line. The end point itself is never drawn. A start request whose
// endpoints are equal, or a step request with no active line, yields nothing.
// A start request issued while a line is active drops that line.
// The master channel carries one pixel per transaction, with tlast set on the
// final pixel of the line. pixel_y is two's complement and may read -1.
// An accepted request is held in the input register; the walker then computes
// its pixel and loads the result register, which drives the master channel.
// Throughput is one request per cycle when the receiver does not stall, set by
// the single pass through the walker's decision adder and coordinate adders.
// When the receiver stalls, the result register holds its pixel and the input
// register holds one more request; tready falls only when both are full.
// Reset (aresetn low, synchronous) empties both registers and ends any line.
module midpoint_line_rasterizer_top import mlr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // From bit 0 up: start_x, start_y, end_x, end_y, zero padding.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // Bit 0: req_type (0 start a line, 1 next pixel).
    input  logic                                   s_axis_tuser,

    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // From bit 0 up: pixel_x, pixel_y (signed), zero padding.
    output logic [((2*COORD_BITS+1+7)/8)*8-1:0]    m_axis_tdata,
    output logic                                   m_axis_tlast
);

    localparam int IN_W        = 4 * COORD_BITS;
    localparam int OUT_W       = 2 * COORD_BITS + 1;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    logic                    item_valid;
    logic                    item_req;
    logic [IN_W-1:0]         item_coords;
    logic                    load_ok;
    logic                    advance;
    res_ctrl_t               res_ctrl;
    logic [COORD_BITS-1:0]   res_x;
    logic [COORD_BITS:0]     res_y;
    logic [COORD_BITS-1:0]   out_x;
    logic [COORD_BITS:0]     out_y;

    // A held request is processed whenever the result register can take
    // whatever it produces.
    assign advance = item_valid && load_ok;

    mlr_in_stage #(
        .COORD_BITS(COORD_BITS)
    ) u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (s_axis_tuser),
        .in_coords  (s_axis_tdata[IN_W-1:0]),
        .advance    (advance),
        .item_valid (item_valid),
        .item_req   (item_req),
        .item_coords(item_coords)
    );

    mlr_walker #(
        .COORD_BITS(COORD_BITS)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item_req   (item_req),
        .item_coords(item_coords),
        .res_ctrl   (res_ctrl),
        .res_x      (res_x),
        .res_y      (res_y)
    );

    mlr_out_stage #(
        .COORD_BITS(COORD_BITS)
    ) u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .res_ctrl (res_ctrl),
        .res_x    (res_x),
        .res_y    (res_y),
        .load_ok  (load_ok),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_last (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_y, out_x};

endmodule
